@@ rtl/fbpa_pkg.sv @@
package fbpa_pkg;

    // fixed field widths of the request and result ports
    localparam int OPCODE_W = 2;
    localparam int INDEX_W  = 6;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    // pool size defaults
    localparam int DEF_POOL_BLOCKS   = 64;
    localparam int RST_BLOCK_COUNT   = 64;

    // request opcodes
    localparam logic [OPCODE_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_REINIT  = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_NOP     = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd2;

endpackage

@@ rtl/fbpa_cell.sv @@
module fbpa_cell import fbpa_pkg::*; #(
    parameter int LINK_W = 7
) (
    input  logic              i_clk,
    input  logic [LINK_W-1:0] i_shift_in,
    input  logic              i_load,
    input  logic [LINK_W-1:0] i_load_data,
    output logic [LINK_W-1:0] o_link
);

    logic [LINK_W-1:0] r_link;

    // take the neighbor's link every cycle, or a new one when loaded
    always_ff @(posedge i_clk) begin
        r_link <= i_load ? i_load_data : i_shift_in;
    end

    assign o_link = r_link;

endmodule

@@ rtl/fbpa_ring.sv @@
module fbpa_ring import fbpa_pkg::*; #(
    parameter int POOL_BLOCKS = DEF_POOL_BLOCKS,
    parameter int LINK_W      = $clog2(POOL_BLOCKS + 1),
    parameter int SLOT_W      = (POOL_BLOCKS > 1) ? $clog2(POOL_BLOCKS) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  logic [LINK_W-1:0] i_wr_data,
    output logic [SLOT_W-1:0] o_slot,
    output logic [LINK_W-1:0] o_link
);

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(POOL_BLOCKS - 1);

    logic [LINK_W-1:0] w_link [POOL_BLOCKS];
    logic [SLOT_W-1:0] r_slot;
    logic [SLOT_W-1:0] n_slot;

    // ring of link cells, rotating one place toward cell 0 each cycle
    for (genvar k = 0; k < POOL_BLOCKS; k++) begin : g_cell
        if (k == POOL_BLOCKS - 1) begin : g_tail
            fbpa_cell #(.LINK_W(LINK_W)) u_cell (
                .i_clk       (i_clk),
                .i_shift_in  (w_link[0]),
                .i_load      (i_wr_en),
                .i_load_data (i_wr_data),
                .o_link      (w_link[k])
            );
        end else begin : g_body
            fbpa_cell #(.LINK_W(LINK_W)) u_cell (
                .i_clk       (i_clk),
                .i_shift_in  (w_link[k+1]),
                .i_load      (1'b0),
                .i_load_data (i_wr_data),
                .o_link      (w_link[k])
            );
        end
    end

    // block index whose link sits in cell 0
    always_comb begin
        if (r_slot == LAST_SLOT) begin
            n_slot = '0;
        end else begin
            n_slot = r_slot + SLOT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
        end else begin
            r_slot <= n_slot;
        end
    end

    assign o_slot = r_slot;
    assign o_link = w_link[0];

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_slot} < (SLOT_W + 1)'(POOL_BLOCKS)))
        else $error("ring slot beyond pool");

endmodule

@@ rtl/fixed_block_pool_allocator_core.sv @@
// fixed-size block pool allocator, last-in-first-out free list of block indices
//
// request channel: i_start with i_opcode / i_block_index, taken when o_busy is low.
//   allocate pops a block, release pushes one back, reinitialize frees the whole
//   pool using the latched block count (saturated to POOL_BLOCKS).
// result channel: o_done strobes for one cycle with o_status, o_granted_block and
//   o_free_count; there is no back-pressure, the receiver takes every result.
// config channel: i_cfg_valid / o_cfg_ready / i_cfg_data writes block_count,
//   which takes effect at the next reinitialize; o_cfg_ready is always high.
// request handling: a request that needs no link access (allocate from untouched
//   blocks, any rejected request, reinitialize, unused opcode) reports in the cycle
//   after it is taken. a list pop or push waits for the block's link cell to rotate
//   into the access point of the ring; the ring of POOL_BLOCKS link cells advances
//   one place per cycle.
// one request is handled at a time; o_busy stays high until its result strobes.
// reset: pool of 64 blocks (capped at POOL_BLOCKS), all untouched, list empty.
//   link cells need no clearing, a link is read only after its block was pushed.
module fixed_block_pool_allocator_core import fbpa_pkg::*; #(
    parameter int POOL_BLOCKS = DEF_POOL_BLOCKS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  logic [OPCODE_W-1:0] i_opcode,
    input  logic [INDEX_W-1:0]  i_block_index,
    output logic                o_done,
    output logic [STATUS_W-1:0] o_status,
    output logic [INDEX_W-1:0]  o_granted_block,
    output logic [COUNT_W-1:0]  o_free_count,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [COUNT_W-1:0]  i_cfg_data
);

    // head / count width holds 0..POOL_BLOCKS, the top value is the empty marker
    localparam int LINK_W = $clog2(POOL_BLOCKS + 1);
    localparam int SLOT_W = (POOL_BLOCKS > 1) ? $clog2(POOL_BLOCKS) : 1;
    localparam int CMP_W  = (LINK_W > COUNT_W) ? LINK_W : COUNT_W;

    localparam logic [LINK_W-1:0] LIST_EMPTY = LINK_W'(POOL_BLOCKS);
    localparam logic [CMP_W-1:0]  POOL_CMP   = CMP_W'(POOL_BLOCKS);
    localparam int RST_POOL = (RST_BLOCK_COUNT > POOL_BLOCKS) ? POOL_BLOCKS
                                                              : RST_BLOCK_COUNT;

    // sequencer states
    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_WAIT_RD = 2'd1;
    localparam logic [1:0] S_WAIT_WR = 2'd2;

    logic [1:0]          r_state,     n_state;
    logic [COUNT_W-1:0]  r_block_count;
    logic [LINK_W-1:0]   r_pool_size, n_pool_size;
    logic [LINK_W-1:0]   r_untouched, n_untouched;
    logic [LINK_W-1:0]   r_free,      n_free;
    logic [LINK_W-1:0]   r_head,      n_head;
    logic [SLOT_W-1:0]   r_target,    n_target;
    logic                r_done,      n_done;
    logic [STATUS_W-1:0] r_status,    n_status;
    logic [LINK_W-1:0]   r_granted,   n_granted;

    logic                w_accept;
    logic                w_hit;
    logic                w_wr_en;
    logic [SLOT_W-1:0]   w_slot;
    logic [LINK_W-1:0]   w_link;
    logic [CMP_W-1:0]    w_bc_ext;
    logic [LINK_W-1:0]   w_bc_sat;
    logic [CMP_W-1:0]    w_idx_ext;
    logic [CMP_W-1:0]    w_grant_ext;
    logic [CMP_W-1:0]    w_free_ext;
    logic                w_bad_index;

    fbpa_ring #(
        .POOL_BLOCKS (POOL_BLOCKS),
        .LINK_W      (LINK_W),
        .SLOT_W      (SLOT_W)
    ) u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_wr_en),
        .i_wr_data (r_head),
        .o_slot    (w_slot),
        .o_link    (w_link)
    );

    assign w_accept = i_start && (r_state == S_IDLE);
    assign w_hit    = (w_slot == r_target);
    // a push lands in the tail cell just as the block's old link leaves cell 0
    assign w_wr_en  = (r_state == S_WAIT_WR) && w_hit;

    // configured block count capped at the pool capacity
    assign w_bc_ext = CMP_W'(r_block_count);
    assign w_bc_sat = (w_bc_ext > POOL_CMP) ? LIST_EMPTY : LINK_W'(r_block_count);

    // release rejected: beyond the pool, or pool already all free (duplicate)
    assign w_idx_ext   = CMP_W'(i_block_index);
    assign w_bad_index = (w_idx_ext >= CMP_W'(r_pool_size)) || (w_idx_ext >= POOL_CMP)
                         || (r_free >= r_pool_size);

    always_comb begin
        n_state     = r_state;
        n_pool_size = r_pool_size;
        n_untouched = r_untouched;
        n_free      = r_free;
        n_head      = r_head;
        n_target    = r_target;
        n_done      = 1'b0;
        n_status    = r_status;
        n_granted   = r_granted;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_status  = ST_OK;
                    n_granted = '0;
                    unique case (i_opcode)
                        OP_ALLOC: begin
                            if (r_free == '0) begin
                                n_status = ST_EMPTY;
                                n_done   = 1'b1;
                            end else if (r_head != LIST_EMPTY) begin
                                // pop from the released list, wait for its link
                                n_target = r_head[SLOT_W-1:0];
                                n_state  = S_WAIT_RD;
                            end else if (r_untouched != '0) begin
                                n_untouched = r_untouched - LINK_W'(1);
                                n_granted   = r_untouched - LINK_W'(1);
                                n_free      = r_free - LINK_W'(1);
                                n_done      = 1'b1;
                            end else begin
                                // list cut short by duplicate releases
                                n_status = ST_EMPTY;
                                n_done   = 1'b1;
                            end
                        end
                        OP_RELEASE: begin
                            if (w_bad_index) begin
                                n_status = ST_BAD_INDEX;
                                n_done   = 1'b1;
                            end else begin
                                n_target = i_block_index[SLOT_W-1:0];
                                n_state  = S_WAIT_WR;
                            end
                        end
                        OP_REINIT: begin
                            n_pool_size = w_bc_sat;
                            n_untouched = w_bc_sat;
                            n_free      = w_bc_sat;
                            n_head      = LIST_EMPTY;
                            n_done      = 1'b1;
                        end
                        default: begin
                            // unused opcode: no change, status ok
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_WAIT_RD: begin
                if (w_hit) begin
                    n_granted = LINK_W'(r_target);
                    n_head    = w_link;
                    n_free    = r_free - LINK_W'(1);
                    n_done    = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_WAIT_WR: begin
                if (w_hit) begin
                    n_head  = LINK_W'(r_target);
                    n_free  = r_free + LINK_W'(1);
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_block_count <= COUNT_W'(RST_BLOCK_COUNT);
            r_pool_size   <= LINK_W'(RST_POOL);
            r_untouched   <= LINK_W'(RST_POOL);
            r_free        <= LINK_W'(RST_POOL);
            r_head        <= LIST_EMPTY;
            r_target      <= '0;
            r_done        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pool_size <= n_pool_size;
            r_untouched <= n_untouched;
            r_free      <= n_free;
            r_head      <= n_head;
            r_target    <= n_target;
            r_done      <= n_done;
            if (i_cfg_valid && o_cfg_ready) begin
                r_block_count <= i_cfg_data;
            end
        end
    end

    // result fields, valid with the done strobe
    always_ff @(posedge i_clk) begin
        r_status  <= n_status;
        r_granted <= n_granted;
    end

    assign w_grant_ext = CMP_W'(r_granted);
    assign w_free_ext  = CMP_W'(r_free);

    assign o_busy          = (r_state != S_IDLE);
    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_granted_block = w_grant_ext[INDEX_W-1:0];
    assign o_free_count    = w_free_ext[COUNT_W-1:0];
    assign o_cfg_ready     = 1'b1;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("result strobed while a request is still in flight");

    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= r_pool_size)
        else $error("free count above pool size");

    a_quick_ops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_opcode == OP_REINIT || i_opcode == OP_NOP))
        |=> (o_done && !o_busy))
        else $error("reinitialize or unused opcode did not finish in one cycle");

    a_wait_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_busy && !w_hit) |=> ($stable(r_free) && $stable(r_head) && !o_done))
        else $error("list state moved while waiting for the link cell");

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

import fbpa_pkg::*;

typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  granted;
    logic [COUNT_W-1:0]  free_count;
} t_pool_result;

class pool_scoreboard;
    // free list predictor state, link cells wide enough for the end marker
    logic [COUNT_W-1:0] next_link [DEF_POOL_BLOCKS];
    logic [COUNT_W-1:0] list_head;
    logic [COUNT_W-1:0] untouched;
    logic [COUNT_W-1:0] free_blocks;
    logic [COUNT_W-1:0] pool_size;
    logic [COUNT_W-1:0] block_count;
    t_pool_result       pending_q[$];
    int                 mismatches;

    function new();
        foreach (next_link[k]) next_link[k] = '0;
        block_count = COUNT_W'(RST_BLOCK_COUNT);
        mismatches  = 0;
        rebuild_pool();
    endfunction

    function void rebuild_pool();
        pool_size = (block_count > COUNT_W'(DEF_POOL_BLOCKS)) ?
                    COUNT_W'(DEF_POOL_BLOCKS) : block_count;
        untouched   = pool_size;
        free_blocks = pool_size;
        list_head   = COUNT_W'(DEF_POOL_BLOCKS);
    endfunction

    function void write_block_count(logic [COUNT_W-1:0] value);
        block_count = value;
    endfunction

    // predict the result of an accepted request and queue it
    function t_pool_result note_request(logic [OPCODE_W-1:0] op, logic [INDEX_W-1:0] idx);
        t_pool_result r;
        r = '0;
        r.status = ST_OK;
        case (op)
            OP_ALLOC: begin
                if (free_blocks == '0) begin
                    r.status = ST_EMPTY;
                end else if (list_head < COUNT_W'(DEF_POOL_BLOCKS)) begin
                    r.granted   = list_head[INDEX_W-1:0];
                    list_head   = next_link[r.granted];
                    free_blocks = free_blocks - 1'b1;
                end else if (untouched != '0) begin
                    untouched   = untouched - 1'b1;
                    r.granted   = untouched[INDEX_W-1:0];
                    free_blocks = free_blocks - 1'b1;
                end else begin
                    r.status = ST_EMPTY;
                end
            end
            OP_RELEASE: begin
                if ({1'b0, idx} >= pool_size || free_blocks >= pool_size) begin
                    r.status = ST_BAD_INDEX;
                end else begin
                    next_link[idx] = list_head;
                    list_head      = {1'b0, idx};
                    free_blocks    = free_blocks + 1'b1;
                end
            end
            OP_REINIT: rebuild_pool();
            default: ;
        endcase
        r.free_count = free_blocks;
        pending_q.push_back(r);
        return r;
    endfunction

    task report_mismatch(string msg);
        if (mismatches < 40) $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task check_result(logic [STATUS_W-1:0] st, logic [INDEX_W-1:0] blk,
                      logic [COUNT_W-1:0] cnt);
        t_pool_result want;
        if (pending_q.size() == 0) begin
            report_mismatch($sformatf("unrequested result status %0d block %0d free %0d",
                                      st, blk, cnt));
            return;
        end
        want = pending_q.pop_front();
        if (st !== want.status)
            report_mismatch($sformatf("status %0d, predicted %0d", st, want.status));
        if (blk !== want.granted)
            report_mismatch($sformatf("granted block %0d, predicted %0d", blk, want.granted));
        if (cnt !== want.free_count)
            report_mismatch($sformatf("free count %0d, predicted %0d", cnt, want.free_count));
    endtask
endclass

module testbench;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_start;
    logic                o_busy;
    logic [OPCODE_W-1:0] i_opcode;
    logic [INDEX_W-1:0]  i_block_index;
    logic                o_done;
    logic [STATUS_W-1:0] o_status;
    logic [INDEX_W-1:0]  o_granted_block;
    logic [COUNT_W-1:0]  o_free_count;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [COUNT_W-1:0]  i_cfg_data;

    pool_scoreboard pool_sb;
    int unsigned    burst_left;
    // blocks currently handed out, used to build realistic release traffic
    int             held_blocks[$];

    fixed_block_pool_allocator_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_opcode        (i_opcode),
        .i_block_index   (i_block_index),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_granted_block (o_granted_block),
        .o_free_count    (o_free_count),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // result monitor: the strobe lasts one cycle and cannot be held off,
    // so every strobe seen at a rising edge is a result
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_done === 1'b1)
            pool_sb.check_result(o_status, o_granted_block, o_free_count);
    end

    // drive one request at the falling edge and hold it until taken;
    // returns at the next falling edge with nothing driven yet there
    task automatic issue(input logic [OPCODE_W-1:0] op, input logic [INDEX_W-1:0] idx,
                         output t_pool_result predicted);
        i_start       <= 1'b1;
        i_opcode      <= op;
        i_block_index <= idx;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        predicted = pool_sb.note_request(op, idx);
        @(negedge i_clk);
    endtask

    // bursts of random length with random gaps, long stretches now and then
    task automatic pace();
        int unsigned gap;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) :
                                                       $urandom_range(1, 10);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_start <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    // one request plus bookkeeping of which blocks are out
    task automatic request(input logic [OPCODE_W-1:0] op, input logic [INDEX_W-1:0] idx);
        t_pool_result predicted;
        int           k;
        issue(op, idx, predicted);
        if (op == OP_ALLOC && predicted.status == ST_OK) begin
            held_blocks.push_back(int'(predicted.granted));
        end else if (op == OP_RELEASE && predicted.status == ST_OK) begin
            for (k = 0; k < held_blocks.size(); k++) begin
                if (held_blocks[k] == int'(idx)) begin
                    held_blocks.delete(k);
                    break;
                end
            end
        end else if (op == OP_REINIT) begin
            held_blocks.delete();
        end
        pace();
    endtask

    // wait until every predicted result has come back, plus a little margin
    task automatic drain();
        i_start <= 1'b0;
        while (pool_sb.pending_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // register write only while the core is idle
    task automatic set_block_count(input logic [COUNT_W-1:0] value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        pool_sb.write_block_count(value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // mostly well-formed traffic: allocates and releases of blocks that are out,
    // with noise releases (out of range, duplicates), reinitialize and unused opcode
    task automatic random_traffic(input int count);
        int unsigned         alloc_pct;
        int unsigned         roll;
        int unsigned         top;
        int                  pos;
        int                  k;
        logic [INDEX_W-1:0]  idx;
        alloc_pct = $urandom_range(20, 80);
        for (k = 0; k < count; k++) begin
            // drift between draining and refilling the pool
            if (k % 40 == 39) alloc_pct = $urandom_range(20, 80);
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                request(OP_REINIT, INDEX_W'($urandom));
            end else if (roll < 6) begin
                request(OP_NOP, INDEX_W'($urandom));
            end else if (roll < 14) begin
                request(OP_RELEASE, INDEX_W'($urandom));
            end else if (roll < 14 + (86 * alloc_pct) / 100) begin
                request(OP_ALLOC, INDEX_W'($urandom));
            end else if (held_blocks.size() != 0) begin
                pos = $urandom_range(0, held_blocks.size() - 1);
                request(OP_RELEASE, INDEX_W'(held_blocks[pos]));
            end else begin
                top = (pool_sb.pool_size == '0) ? 0 : int'(pool_sb.pool_size) - 1;
                idx = INDEX_W'($urandom_range(0, top));
                request(OP_RELEASE, idx);
            end
        end
    endtask

    initial begin
        pool_sb       = new();
        burst_left    = 0;
        i_rst_n       = 1'b0;
        i_start       = 1'b0;
        i_opcode      = OP_ALLOC;
        i_block_index = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset pool of 64: untouched blocks come out highest first
        request(OP_ALLOC, 6'd0);
        request(OP_ALLOC, 6'd0);
        request(OP_ALLOC, 6'd0);
        // released blocks are served before untouched ones, last in first out
        request(OP_RELEASE, 6'd62);
        request(OP_RELEASE, 6'd61);
        request(OP_ALLOC, 6'd63);
        request(OP_ALLOC, 6'd0);
        // release of a block that was never handed out is accepted
        request(OP_RELEASE, 6'd0);
        request(OP_ALLOC, 6'd0);
        // duplicate release pushes the same block twice
        request(OP_RELEASE, 6'd63);
        request(OP_RELEASE, 6'd63);
        request(OP_ALLOC, 6'd0);
        request(OP_ALLOC, 6'd0);
        // unused opcode changes nothing
        request(OP_NOP, 6'd63);
        request(OP_NOP, 6'd0);
        // release into a full pool is rejected
        request(OP_REINIT, 6'd63);
        request(OP_RELEASE, 6'd5);
        random_traffic(70);

        // single block pool: exhaustion, out of range and full pool rejects
        set_block_count(7'd1);
        request(OP_REINIT, 6'd0);
        request(OP_ALLOC, 6'd0);
        request(OP_ALLOC, 6'd0);
        request(OP_RELEASE, 6'd1);
        request(OP_RELEASE, 6'd63);
        request(OP_RELEASE, 6'd0);
        request(OP_RELEASE, 6'd0);
        random_traffic(40);

        // empty pool: every allocate and release is refused
        set_block_count(7'd0);
        request(OP_REINIT, 6'd0);
        request(OP_ALLOC, 6'd0);
        request(OP_RELEASE, 6'd0);
        random_traffic(15);

        // count above the pool limit saturates; drain it all the way
        set_block_count(7'd127);
        request(OP_REINIT, 6'd0);
        repeat (66) request(OP_ALLOC, INDEX_W'($urandom));
        random_traffic(60);

        // small pool, many indices out of range
        set_block_count(7'd5);
        request(OP_REINIT, 6'd0);
        random_traffic(50);

        set_block_count(7'd64);
        request(OP_REINIT, 6'd0);
        random_traffic(40);

        // new count only takes hold at the next reinitialize
        set_block_count(7'd9);
        random_traffic(40);

        drain();
        repeat (70) @(negedge i_clk);
        if (pool_sb.pending_q.size() != 0)
            pool_sb.report_mismatch($sformatf("%0d results never arrived",
                                              pool_sb.pending_q.size()));
        if (pool_sb.mismatches == 0) begin
            $display("** fixed_block_pool_allocator_core: PASSED **");
        end else begin
            $display("** fixed_block_pool_allocator_core: FAILED **");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #5ms;
        $display("** fixed_block_pool_allocator_core: FAILED **");
        $finish;
    end

endmodule

@@ fixed_block_pool_allocator_core.f @@
rtl/fbpa_pkg.sv
rtl/fbpa_cell.sv
rtl/fbpa_ring.sv
rtl/fixed_block_pool_allocator_core.sv
tb/sv/testbench.sv
